// ----- hw/rtl/tcc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_pkg
// shared types and constants of the thrust curve conversion
// ----------------------------------------------------------------------------
package tcc_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 24;

	localparam logic [CfgIdxW-1:0] REG_COEF_A = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_COEF_B = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_COEF_C = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_MIN_CMD = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_MAX_CMD = 3'd4;

	localparam logic [15:0] FULL_SCALE = 16'd65520;

	// square root: 28 result bits, two bits a stage
	localparam int unsigned SqrtSteps = 28;
	localparam int unsigned SqrtPerStage = 2;
	localparam int unsigned SqrtStages = SqrtSteps / SqrtPerStage;
	// divider: dividend below 2^44, so a divisor of 1 needs 44 quotient bits
	localparam int unsigned DivBits = 44;
	localparam int unsigned DivPerStage = 2;
	localparam int unsigned DivStages = DivBits / DivPerStage;

	typedef struct packed {
		logic [23:0] coef_a;
		logic [23:0] coef_b;
		logic [23:0] coef_c;
		logic [15:0] min_command;
		logic [15:0] max_command;
	} cfg_t;

	typedef struct packed {
		logic               kind;
		logic [15:0]        command_in;
		logic signed [23:0] force_in;
	} in_t;

	typedef struct packed {
		logic signed [23:0] force_out;
		logic [15:0]        command_out;
		logic               limited;
	} out_t;

endpackage : tcc_pkg
`default_nettype wire

// ----- hw/rtl/tcc_stream_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_stream_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface tcc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface : tcc_stream_if
`default_nettype wire

// ----- hw/rtl/thrust_curve_conversion.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// thrust_curve_conversion
// command to force and force to command on a quadratic thrust curve
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  req       in   kind, command_in, force_in
//  rsp       out  force_out, command_out, limited
//  cfg       in   cfg_we, cfg_idx, cfg_data
//
//  one beat a cycle while the output buffer has space; the pipe holds 4 setup stages,
//  14 root stages, numerator, 22 divider stages and clamp, then the output buffer
//  the whole pipe advances together; it halts when the output buffer is full
//  the divider and root stages set the depth; reset clears the valid bits, the buffer
//  state and the config registers, which return to their documented reset values
module thrust_curve_conversion
	import tcc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_idx,
	input  wire logic [CfgDataW-1:0] cfg_data,
	tcc_stream_if.sink               req,
	tcc_stream_if.source             rsp
);
	cfg_t cfg_q;
	logic en;
	logic cv;
	out_t cd;
	logic space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_a <= 24'd3107507;
			cfg_q.coef_b <= 24'd21171;
			cfg_q.coef_c <= 24'd82390;
			cfg_q.min_command <= 16'd3200;
			cfg_q.max_command <= 16'd64000;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_COEF_A: cfg_q.coef_a <= cfg_data;
				REG_COEF_B: cfg_q.coef_b <= cfg_data;
				REG_COEF_C: cfg_q.coef_c <= cfg_data;
				REG_MIN_CMD: cfg_q.min_command <= cfg_data[15:0];
				REG_MAX_CMD: cfg_q.max_command <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign en = space;
	assign req.ready = en;

	tcc_core u_core (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(req.valid), .in_data(req.data), .cfg(cfg_q),
		.out_valid(cv), .out_data(cd)
	);

	tcc_skid u_skid (
		.clk(clk), .arst_n(arst_n),
		.in_valid(cv && en), .in_data(cd), .space(space), .result(rsp)
	);
endmodule : thrust_curve_conversion
`default_nettype wire

// ----- hw/rtl/tcc_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_core
// pipelined evaluation and inversion of the thrust curve; a single enable
// advances every stage so a stall holds the whole pipe
// ----------------------------------------------------------------------------
module tcc_core
	import tcc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire in_t  in_data,
	input  wire cfg_t cfg,
	output logic      out_valid,
	output out_t      out_data
);
	// ---------------- stage 1: products ----------------
	logic               v_s1;
	logic               kind_s1;
	logic               fwd_ok_s1;
	logic [31:0]        ksq_s1;
	logic signed [40:0] bk_s1;
	logic signed [47:0] bsq_s1;
	logic signed [25:0] cmf_s1;

	logic signed [24:0] f_clamped;
	assign f_clamped = in_data.force_in[23] ? 25'sd0 : {1'b0, in_data.force_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= in_data.kind;
			fwd_ok_s1 <= (in_data.command_in != 16'd0) && (in_data.command_in <= FULL_SCALE);
			ksq_s1 <= 32'(in_data.command_in) * 32'(in_data.command_in);
			bk_s1 <= 41'($signed(cfg.coef_b) * $signed({1'b0, in_data.command_in}));
			bsq_s1 <= 48'($signed(cfg.coef_b) * $signed(cfg.coef_b));
			cmf_s1 <= 26'($signed(cfg.coef_c)) - 26'(f_clamped);
		end
	end

	// ---------------- stage 2: a*k^2, 4a(c-f) ----------------
	logic               v_s2;
	logic               kind_s2;
	logic               fwd_ok_s2;
	logic [55:0]        aksq_s2;
	logic signed [40:0] bk_s2;
	logic signed [51:0] ac4_s2;
	logic signed [55:0] bsq8_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= kind_s1;
			fwd_ok_s2 <= fwd_ok_s1;
			aksq_s2 <= 56'(cfg.coef_a) * 56'(ksq_s1);
			bk_s2 <= bk_s1;
			ac4_s2 <= 52'($signed({1'b0, cfg.coef_a}) * cmf_s1) <<< 2;
			bsq8_s2 <= 56'(bsq_s1) <<< 8;
		end
	end

	// ---------------- stage 3: sums ----------------
	logic               v_s3;
	logic               kind_s3;
	logic               fwd_ok_s3;
	logic signed [63:0] num_s3;
	logic signed [57:0] disc_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s3 <= kind_s2;
			fwd_ok_s3 <= fwd_ok_s2;
			num_s3 <= $signed({8'd0, aksq_s2}) + (64'(bk_s2) <<< 20)
				+ (64'($signed(cfg.coef_c)) <<< 32);
			disc_s3 <= 58'(bsq8_s2) - 58'(ac4_s2);
		end
	end

	// ---------------- stage 4: forward rounding, saturation ----------------
	logic               v_s4;
	logic               kind_s4;
	logic signed [23:0] fout_s4;
	logic               flim_s4;
	logic               dneg_s4;
	logic [55:0]        disc_s4;

	logic signed [31:0] fr;
	assign fr = 32'((num_s3 + 64'sd2147483648) >>> 32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s4 <= kind_s3;
			dneg_s4 <= disc_s3[57];
			disc_s4 <= disc_s3[55:0];
			if (!fwd_ok_s3) begin
				fout_s4 <= '0;
				flim_s4 <= 1'b0;
			end else if (fr > 32'sd8388607) begin
				fout_s4 <= 24'sh7FFFFF;
				flim_s4 <= 1'b1;
			end else if (fr < -32'sd8388608) begin
				fout_s4 <= 24'sh800000;
				flim_s4 <= 1'b1;
			end else begin
				fout_s4 <= fr[23:0];
				flim_s4 <= 1'b0;
			end
		end
	end

	// ---------------- square root stages ----------------
	logic [SqrtStages:0]       sv;
	logic [SqrtStages:0]       skind;
	logic [SqrtStages:0]       sdneg;
	logic signed [23:0]        sfout [SqrtStages+1];
	logic [SqrtStages:0]       sflim;
	logic [55:0]               sx    [SqrtStages+1];
	logic [55:0]               sres  [SqrtStages+1];

	assign sv[0] = v_s4;
	assign skind[0] = kind_s4;
	assign sdneg[0] = dneg_s4;
	assign sfout[0] = fout_s4;
	assign sflim[0] = flim_s4;
	assign sx[0] = disc_s4;
	assign sres[0] = '0;

	for (genvar g = 0; g < SqrtStages; g++) begin : g_sqrt
		logic [55:0] x_n;
		logic [55:0] r_n;
		always_comb begin
			logic [55:0] x;
			logic [55:0] r;
			logic [55:0] b;
			x = sx[g];
			r = sres[g];
			for (int j = 0; j < SqrtPerStage; j++) begin
				b = 56'(1) << (54 - 2 * (g * SqrtPerStage + j));
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
			end
			x_n = x;
			r_n = r;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv[g+1] <= 1'b0;
			end else if (en) begin
				sv[g+1] <= sv[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				skind[g+1] <= skind[g];
				sdneg[g+1] <= sdneg[g];
				sfout[g+1] <= sfout[g];
				sflim[g+1] <= sflim[g];
				sx[g+1] <= x_n;
				sres[g+1] <= r_n;
			end
		end
	end

	// ---------------- numerator ----------------
	logic               v_n;
	logic               kind_n;
	logic               inv_bad_n;
	logic signed [23:0] fout_n;
	logic               flim_n;
	logic [63:0]        dividend_n;

	logic signed [29:0] nval;
	assign nval = $signed({2'b0, sres[SqrtStages][27:0]}) - (30'($signed(cfg.coef_b)) <<< 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_n <= 1'b0;
		end else if (en) begin
			v_n <= sv[SqrtStages];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_n <= skind[SqrtStages];
			inv_bad_n <= sdneg[SqrtStages] || nval[29];
			fout_n <= sfout[SqrtStages];
			flim_n <= sflim[SqrtStages];
			dividend_n <= (64'(nval[28:0]) << 15) + 64'(cfg.coef_a[23:1]);
		end
	end

	// ---------------- restoring divider stages ----------------
	// dividend below 2^44, so the starting remainder is zero and the
	// quotient always fits DivBits
	logic [DivStages:0]  dv;
	logic [DivStages:0]  dkind;
	logic [DivStages:0]  dbad;
	logic signed [23:0]  dfout [DivStages+1];
	logic [DivStages:0]  dflim;
	logic [24:0]         drem  [DivStages+1];
	logic [63:0]         dnum  [DivStages+1];
	logic [DivBits-1:0]  dquo  [DivStages+1];

	assign dv[0] = v_n;
	assign dkind[0] = kind_n;
	assign dbad[0] = inv_bad_n;
	assign dfout[0] = fout_n;
	assign dflim[0] = flim_n;
	// top bits above the quotient range go in as the starting remainder
	assign drem[0] = 25'(dividend_n[63:DivBits]);
	assign dnum[0] = dividend_n;
	assign dquo[0] = '0;

	for (genvar g = 0; g < DivStages; g++) begin : g_div
		logic [24:0]        r_n;
		logic [DivBits-1:0] q_n;
		always_comb begin
			logic [25:0] t;
			logic [24:0] r;
			logic [DivBits-1:0] q;
			r = drem[g];
			q = dquo[g];
			for (int j = 0; j < DivPerStage; j++) begin
				t = {r, dnum[g][DivBits-1-(g*DivPerStage+j)]};
				q = q << 1;
				if (t >= {2'b0, cfg.coef_a}) begin
					t = t - {2'b0, cfg.coef_a};
					q[0] = 1'b1;
				end
				r = t[24:0];
			end
			r_n = r;
			q_n = q;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv[g+1] <= 1'b0;
			end else if (en) begin
				dv[g+1] <= dv[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dkind[g+1] <= dkind[g];
				dbad[g+1] <= dbad[g];
				dfout[g+1] <= dfout[g];
				dflim[g+1] <= dflim[g];
				drem[g+1] <= r_n;
				dnum[g+1] <= dnum[g];
				dquo[g+1] <= q_n;
			end
		end
	end

	// ---------------- clamp and output ----------------
	localparam int unsigned D = DivStages;
	logic [DivBits-1:0] q;
	logic [DivBits-1:0] qc;
	logic               qsat;
	// a zero divisor sets every quotient bit, matching saturation high
	assign q = dbad[D] ? '0 : dquo[D];
	assign qsat = (cfg.coef_a == '0) && !dbad[D];
	always_comb begin
		qc = q;
		if (!qsat && qc < DivBits'(cfg.min_command)) qc = DivBits'(cfg.min_command);
		if (qsat || qc > DivBits'(cfg.max_command)) qc = DivBits'(cfg.max_command);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv[D];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dkind[D]) begin
				out_data.force_out <= '0;
				out_data.command_out <= qc[15:0];
				out_data.limited <= dbad[D] || qsat || (qc != q);
			end else begin
				out_data.force_out <= dfout[D];
				out_data.command_out <= '0;
				out_data.limited <= dflim[D];
			end
		end
	end

endmodule : tcc_core
`default_nettype wire

// ----- hw/rtl/tcc_skid.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_skid
// two-entry output buffer so the pipe keeps moving while a beat waits
// ----------------------------------------------------------------------------
module tcc_skid
	import tcc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire out_t in_data,
	output logic      space,
	tcc_stream_if.source result
);
	out_t       buf_q [2];
	logic       rd_q;
	logic       wr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop = result.valid && result.ready;
	assign result.valid = cnt_q != 2'd0;
	assign result.data = buf_q[rd_q];
	// registered so the input side never waits on result.ready in the same cycle
	assign space = cnt_q != 2'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(in_valid) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) buf_q[wr_q] <= in_data;
	end
endmodule : tcc_skid
`default_nettype wire

// ----- hw/rtl/tcc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_checker
// port-level checks bound to the top level
// ----------------------------------------------------------------------------
module tcc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [40:0] rsp_data
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result beat dropped or changed under stall");
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid)
		else $error("request beat withdrawn under stall");
	a_kind_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data[40:17] == '0) || (rsp_data[16:1] == '0))
		else $error("both force and command nonzero");
	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data[16:1] == '0 && rsp_data[40:17] != 24'h7FFFFF
		&& rsp_data[40:17] != 24'h800000 && rsp_data[40:17] != '0 |-> !rsp_data[0])
		else $error("forward flag without saturation");
	a_reset_idle: assert property (@(posedge clk) $rose(arst_n) |-> !rsp_valid)
		else $error("result out of reset");
endmodule : tcc_checker

bind thrust_curve_conversion tcc_checker u_tcc_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// checks both directions of the thrust curve conversion: directed corner
// commands and forces, then random traffic under several register settings,
// with random gaps on both channels and one long output stall
// ----------------------------------------------------------------------------
module tb;
	import tcc_pkg::*;

	localparam int unsigned IdleLimit = 20000;
	localparam int unsigned DrainWait = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_idx = REG_COEF_A;
	logic [CfgDataW-1:0] cfg_data = '0;

	tcc_stream_if #(.payload_t(in_t)) req ();
	tcc_stream_if #(.payload_t(out_t)) rsp ();

	thrust_curve_conversion DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .req(req), .rsp(rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor copy of the registers
	logic [23:0] m_a, m_b, m_c;
	logic [15:0] m_min, m_max;

	in_t  pending_beats[$];
	out_t expected_results[$];
	int   errors = 0;
	int   n_fwd = 0, n_inv = 0, n_lim = 0;
	bit   hold_rsp = 1'b0;
	int   idle_cycles = 0;

	function automatic logic [63:0] root28(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 54;
		for (int i = 0; i < 28; i++) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic out_t convert(in_t beat);
		out_t o;
		longint a, b, c, k, num, f, d, n, frc;
		logic [63:0] q, cmd;
		bit q_ok;
		o = '0;
		a = longint'({40'd0, m_a});
		b = longint'(signed'(m_b));
		c = longint'(signed'(m_c));
		if (beat.kind == 1'b0) begin
			k = longint'({48'd0, beat.command_in});
			if (k != 0 && k <= 65520) begin
				num = a * k * k + b * k * (64'sd1 << 20) + c * (64'sd1 << 32);
				frc = (num + (64'sd1 << 31)) >>> 32;
				if (frc > 8388607) begin
					frc = 8388607;
					o.limited = 1'b1;
				end
				if (frc < -8388608) begin
					frc = -8388608;
					o.limited = 1'b1;
				end
				o.force_out = frc[23:0];
			end
		end else begin
			f = longint'(beat.force_in);
			if (f < 0) f = 0;
			d = b * b * 256 - 4 * a * (c - f);
			q_ok = 1'b1;
			q = 0;
			if (d < 0) begin
				q_ok = 1'b0;
			end else begin
				n = longint'(root28(d)) - 16 * b;
				if (n < 0) q_ok = 1'b0;
				else if (a == 0) q = '1;
				else q = (64'(n) * 32768 + 64'(a / 2)) / 64'(a);
			end
			cmd = q;
			if (cmd < m_min) cmd = m_min;
			if (cmd > m_max) cmd = m_max;
			o.command_out = cmd[15:0];
			o.limited = !q_ok || cmd != q;
		end
		return o;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.data <= '0;
		end else begin
			if (req.valid && req.ready) begin
				expected_results.push_back(convert(req.data));
				if (req.data.kind) n_inv++;
				else n_fwd++;
				void'(pending_beats.pop_front());
			end
			// next beat offered unless a gap is drawn
			if (!(req.valid && !req.ready)) begin
				if (pending_beats.size() > 0 && ($urandom_range(0, 3) != 0)) begin
					req.valid <= 1'b1;
					req.data <= pending_beats[0];
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (rsp.data.limited) n_lim++;
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					out_t e;
					e = expected_results.pop_front();
					if (rsp.data.force_out !== e.force_out) begin
						$error("force_out exp %0d got %0d", e.force_out, rsp.data.force_out);
						errors++;
					end
					if (rsp.data.command_out !== e.command_out) begin
						$error("command_out exp %0d got %0d", e.command_out,
							rsp.data.command_out);
						errors++;
					end
					if (rsp.data.limited !== e.limited) begin
						$error("limited exp %0d got %0d", e.limited, rsp.data.limited);
						errors++;
					end
				end
			end
			if (hold_rsp) rsp.ready <= 1'b0;
			else if ($urandom_range(0, 63) == 0) rsp.ready <= 1'b0;
			else if (!rsp.ready && $urandom_range(0, 3) != 0) rsp.ready <= 1'b1;
			else if ($urandom_range(0, 15) == 0) rsp.ready <= 1'b0;
			else rsp.ready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_COEF_A: m_a = val;
			REG_COEF_B: m_b = val;
			REG_COEF_C: m_c = val;
			REG_MIN_CMD: m_min = val[15:0];
			REG_MAX_CMD: m_max = val[15:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending_beats.size() != 0 || expected_results.size() != 0 || req.valid)
			@(posedge clk);
		repeat (DrainWait) @(posedge clk);
	endtask

	task automatic push_cmd(input logic [15:0] k);
		in_t t;
		t = '0;
		t.command_in = k;
		t.force_in = 24'($urandom);
		pending_beats.push_back(t);
	endtask

	task automatic push_force(input logic [23:0] f);
		in_t t;
		t = '0;
		t.kind = 1'b1;
		t.force_in = f;
		t.command_in = 16'($urandom);
		pending_beats.push_back(t);
	endtask

	task automatic random_beats(input int count);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 5))
				0: push_cmd(16'($urandom));
				1: push_cmd(16'($urandom_range(0, 65520)));
				2: push_cmd(16'($urandom_range(65500, 65535)));
				3: push_force(24'($urandom));
				4: push_force(24'($urandom_range(0, 8388607)));
				default: push_force(24'($urandom_range(0, 2000000)));
			endcase
		end
	endtask

	initial begin
		m_a = 24'd3107507;
		m_b = 24'd21171;
		m_c = 24'd82390;
		m_min = 16'd3200;
		m_max = 16'd64000;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: command extremes, out of range commands, force corners
		push_cmd(16'd0);
		push_cmd(16'd1);
		push_cmd(16'd16);
		push_cmd(16'd32768);
		push_cmd(16'd65520);
		push_cmd(16'd65521);
		push_cmd(16'hFFFF);
		push_force(24'h800000);
		push_force(24'hFFFFFF);
		push_force(24'd0);
		push_force(24'd82390);
		push_force(24'd200000);
		push_force(24'h7FFFFF);
		push_force(24'h555555);
		push_cmd(16'hAAAA);
		push_cmd(16'h5555);
		wait_idle();

		// huge curve to force saturation both ways
		write_reg(REG_COEF_A, 24'hFFFFFF);
		write_reg(REG_COEF_B, 24'h7FFFFF);
		write_reg(REG_COEF_C, 24'h7FFFFF);
		push_cmd(16'd65520);
		push_force(24'd0);
		wait_idle();
		write_reg(REG_COEF_B, 24'h800000);
		write_reg(REG_COEF_C, 24'h800000);
		push_cmd(16'd100);
		push_cmd(16'd65520);
		push_force(24'd100);
		wait_idle();

		// zero coef_a; min above max
		write_reg(REG_COEF_A, 24'd0);
		write_reg(REG_COEF_B, 24'd0);
		write_reg(REG_COEF_C, 24'd0);
		write_reg(REG_MIN_CMD, 16'd65520);
		write_reg(REG_MAX_CMD, 16'd0);
		push_force(24'd5000);
		push_cmd(16'd4000);
		wait_idle();

		// reset values, long output stall
		write_reg(REG_COEF_A, 24'd3107507);
		write_reg(REG_COEF_B, 24'd21171);
		write_reg(REG_COEF_C, 24'd82390);
		write_reg(REG_MIN_CMD, 16'd3200);
		write_reg(REG_MAX_CMD, 16'd64000);
		hold_rsp = 1'b1;
		random_beats(150);
		repeat (300) @(posedge clk);
		hold_rsp = 1'b0;
		wait_idle();

		// random settings, extremes included
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_COEF_A, p == 0 ? 24'd1 : 24'($urandom_range(1, 24'hFFFFFF)));
			write_reg(REG_COEF_B, p == 1 ? 24'h800000 : 24'($urandom) >> $urandom_range(0, 12));
			write_reg(REG_COEF_C, p == 2 ? 24'h7FFFFF : 24'($urandom));
			write_reg(REG_MIN_CMD, 16'($urandom_range(0, 8000)));
			write_reg(REG_MAX_CMD, p == 3 ? 16'd65520 : 16'($urandom_range(30000, 65520)));
			random_beats(75);
			wait_idle();
		end

		$display("tb: %0d forward and %0d inverse conversions checked, %0d limited",
			n_fwd, n_inv, n_lim);
		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end
endmodule : tb
`default_nettype wire
